// File: rtl/core/ssu_pkg.sv
package ssu_pkg;

  // Field widths fixed by the interface
  localparam int VAL_W   = 16;
  localparam int CNT_W   = 9;
  localparam int TGT_W   = 11;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register indexes
  localparam int REG_TARGET_SUM = 0;

  // Reset value of the target register
  localparam logic [TGT_W-1:0] TARGET_RESET = 11'd1;

  // Start command from the front end to the engine
  typedef struct packed {
    logic             go;
    logic [TGT_W-1:0] target;
  } cmd_t;

  // Result from the engine
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] count;
  } res_t;

endpackage

// File: rtl/core/ssu_value_mem.sv
module ssu_value_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [ssu_pkg::VAL_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [ssu_pkg::VAL_W-1:0] rdata
);

  logic [ssu_pkg::VAL_W-1:0] mem [DEPTH];

  // Write one value, read one value with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/ssu_reach_mem.sv
module ssu_reach_mem #(
  parameter int DEPTH = 4144,
  parameter int AW    = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [63:0]   wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [63:0]   rdata_a,
  output logic [63:0]   rdata_b
);

  logic [63:0] mem [DEPTH];

  // One write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: rtl/core/ssu_engine.sv
module ssu_engine #(
  parameter int MAX_ITEMS  = 256,
  parameter int MAX_TARGET = 1024,
  parameter int NW         = 9,
  parameter int VAW        = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ssu_pkg::cmd_t             cmd,
  input  logic [NW-1:0]             n,
  output logic [VAW-1:0]            vrd_addr,
  input  logic [ssu_pkg::VAL_W-1:0] vrd_data,
  output ssu_pkg::res_t             res,
  input  logic                      res_ready
);

  localparam int WORDS = (MAX_TARGET + 63) / 64;
  localparam int WIW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PCW   = $clog2(WORDS + 1);
  localparam int ICW   = $clog2(2 * WORDS);
  localparam int KW0   = $clog2(MAX_TARGET + 1);
  localparam int KW    = (KW0 > 7) ? KW0 : 7;
  localparam int ROWS  = MAX_ITEMS + 3;
  localparam int RW    = $clog2(ROWS);
  localparam int DEPTH = ROWS * WORDS;
  localparam int AW    = $clog2(DEPTH);
  localparam int BROW0 = MAX_ITEMS + 1;
  localparam int BROW1 = MAX_ITEMS + 2;
  localparam int WSW   = ssu_pkg::VAL_W - 6;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_INIT  = 7'b0000010,
    S_FETCH = 7'b0000100,
    S_WAITV = 7'b0001000,
    S_PASS  = 7'b0010000,
    S_CHECK = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    M_SHIFT_F = 2'd0,
    M_LOAD    = 2'd1,
    M_SHIFT_B = 2'd2
  } mode_t;

  state_t                    state;
  mode_t                     mode;
  logic                      back_ph;
  logic                      bsel;
  logic [NW-1:0]             i;
  logic [NW-1:0]             n_r;
  logic [NW-1:0]             tally;
  logic [KW-1:0]             k;
  logic [KW-1:0]             lo;
  logic [ssu_pkg::VAL_W-1:0] v;
  logic [ICW-1:0]            ic;
  logic [PCW-1:0]            pc;
  logic                      d_valid;
  logic                      d_bv;
  logic [WIW-1:0]            d_w;
  logic [63:0]               prev;
  logic                      prev_v;
  logic [63:0]               fregs [WORDS];
  logic [63:0]               bregs [WORDS];
  logic [KW-1:0]             j;
  logic [WIW-1:0]            sw;
  logic                      scanning;

  logic [KW-1:0]  k_in;
  logic [WSW-1:0] ws_eff;
  logic [5:0]     bs_eff;
  logic [RW-1:0]  row_i, row_im1, brow_cur, brow_nxt, row_a, row_b, row_dst;
  logic           issue;
  logic           b_ok;
  logic [WIW-1:0] issue_w, b_word;
  logic [AW-1:0]  raddr_a, raddr_b, waddr;
  logic [63:0]    rdata_a, rdata_b, wdata, shifted;
  logic           we;
  logic [ICW-1:0] ic_word;
  logic [KW-1:0]  hi, e, a;
  logic [WIW-1:0] a_w, e_w;
  logic [63:0]    m;
  logic           hit, bbit, fin, need;

  ssu_reach_mem #(.DEPTH(DEPTH), .AW(AW)) u_reach (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Saturate the target
  assign k_in = (32'(cmd.target) > MAX_TARGET) ? KW'(MAX_TARGET) : KW'(cmd.target);

  // Row selection for the current pass
  always_comb begin
    ws_eff   = (mode == M_LOAD) ? '0 : v[ssu_pkg::VAL_W-1:6];
    bs_eff   = (mode == M_LOAD) ? '0 : v[5:0];
    row_i    = RW'(i);
    row_im1  = row_i - RW'(1);
    brow_cur = bsel ? RW'(BROW1) : RW'(BROW0);
    brow_nxt = bsel ? RW'(BROW0) : RW'(BROW1);
    row_a    = (mode == M_SHIFT_B) ? brow_cur : row_im1;
    row_b    = (mode == M_LOAD) ? brow_cur : row_a;
    row_dst  = (mode == M_SHIFT_B) ? brow_nxt : row_i;
  end

  // Read issue: own word on port A, shifted source word on port B
  always_comb begin
    issue   = (state == S_PASS) && (32'(pc) < WORDS);
    issue_w = WIW'(pc);
    b_ok    = 32'(pc) >= 32'(ws_eff);
    b_word  = WIW'(32'(pc) - 32'(ws_eff));
    raddr_a = AW'(row_a) * AW'(WORDS) + AW'(issue_w);
    raddr_b = AW'(row_b) * AW'(WORDS) + AW'(b_word);
  end

  // Merge returned words into the shifted row
  always_comb begin
    shifted = '0;
    if (d_bv) begin
      shifted = rdata_b << bs_eff;
      if (prev_v && (bs_eff != 6'd0)) begin
        shifted = shifted | (prev >> (7'd64 - {1'b0, bs_eff}));
      end
    end
  end

  // Write port: row setup or pass results
  always_comb begin
    ic_word = (32'(ic) < WORDS) ? ic : ic - ICW'(WORDS);
    if (state == S_INIT) begin
      we    = 1'b1;
      waddr = (32'(ic) < WORDS) ? AW'(ic_word) : AW'(BROW0) * AW'(WORDS) + AW'(ic_word);
      wdata = (ic_word == '0) ? 64'd1 : 64'd0;
    end else begin
      we    = d_valid && (mode != M_LOAD) && (state == S_PASS);
      waddr = AW'(row_dst) * AW'(WORDS) + AW'(d_w);
      wdata = rdata_a | shifted;
    end
  end

  assign vrd_addr = VAW'(i - NW'(1));

  // Window test against the loaded front row
  always_comb begin
    hi   = k - KW'(1);
    e    = hi - j;
    a    = (lo > j) ? lo - j : '0;
    a_w  = WIW'(a >> 6);
    e_w  = WIW'(e >> 6);
    m    = '1;
    if (sw == a_w) begin
      m = m & ({64{1'b1}} << a[5:0]);
    end
    if (sw == e_w) begin
      m = m & ({64{1'b1}} >> (6'd63 - e[5:0]));
    end
    hit  = |(fregs[sw] & m);
    bbit = bregs[WIW'(j >> 6)][j[5:0]];
    fin  = 1'b0;
    need = 1'b0;
    if (v == '0) begin
      fin = 1'b1;
    end else if (!scanning) begin
      fin = (j > hi);
    end else if (hit) begin
      fin  = 1'b1;
      need = 1'b1;
    end
  end

  assign res.valid = (state == S_DONE);
  assign res.count = ssu_pkg::CNT_W'(tally);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      mode     <= M_SHIFT_F;
      back_ph  <= 1'b0;
      bsel     <= 1'b0;
      d_valid  <= 1'b0;
      prev_v   <= 1'b0;
      scanning <= 1'b0;
      i        <= '0;
      tally    <= '0;
    end else begin
      d_valid <= issue;
      d_bv    <= b_ok;
      d_w     <= issue_w;
      case (state)
        S_IDLE: begin
          if (cmd.go) begin
            n_r     <= n;
            k       <= k_in;
            i       <= NW'(1);
            bsel    <= 1'b0;
            back_ph <= 1'b0;
            ic      <= '0;
            if (k_in == '0) begin
              tally <= n;
              state <= S_DONE;
            end else begin
              tally <= '0;
              state <= S_INIT;
            end
          end
        end
        S_INIT: begin
          ic <= ic + ICW'(1);
          if (32'(ic) == 2 * WORDS - 1) begin
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_WAITV;
        end
        S_WAITV: begin
          v        <= vrd_data;
          prev_v   <= 1'b0;
          pc       <= '0;
          j        <= '0;
          scanning <= 1'b0;
          mode     <= back_ph ? M_LOAD : M_SHIFT_F;
          lo       <= (32'(vrd_data) >= 32'(k)) ? '0 : k - KW'(vrd_data);
          state    <= S_PASS;
        end
        S_PASS: begin
          if (d_valid) begin
            prev   <= rdata_b;
            prev_v <= d_bv;
            if (mode == M_LOAD) begin
              fregs[d_w] <= rdata_a;
              bregs[d_w] <= rdata_b;
            end
          end
          if (32'(pc) < WORDS) begin
            pc <= pc + PCW'(1);
          end else begin
            case (mode)
              M_SHIFT_F: begin
                if (i == n_r) begin
                  back_ph <= 1'b1;
                end else begin
                  i <= i + NW'(1);
                end
                state <= S_FETCH;
              end
              M_LOAD: begin
                state <= S_CHECK;
              end
              M_SHIFT_B: begin
                bsel  <= ~bsel;
                i     <= i - NW'(1);
                state <= S_FETCH;
              end
              default: begin
                state <= S_FETCH;
              end
            endcase
          end
        end
        S_CHECK: begin
          if (fin) begin
            scanning <= 1'b0;
            if (!need) begin
              tally <= tally + NW'(1);
            end
            if (i == NW'(1)) begin
              state <= S_DONE;
            end else begin
              mode   <= M_SHIFT_B;
              pc     <= '0;
              prev_v <= 1'b0;
              state  <= S_PASS;
            end
          end else if (!scanning) begin
            if (bbit) begin
              scanning <= 1'b1;
              sw       <= a_w;
            end else begin
              j <= j + KW'(1);
            end
          end else if (sw == e_w) begin
            scanning <= 1'b0;
            j        <= j + KW'(1);
          end else begin
            sw <= sw + WIW'(1);
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/subset_sum_unneeded_counter_unit.sv
// Channel  | Handshake               | Payload
// ---------+-------------------------+---------------------------------
// in       | in_valid / in_ready     | item_value[15:0], is_last
// out      | out_valid / out_ready   | unneeded_count[8:0]
// apb      | psel, penable, pready   | paddr[2:0], pwdata, prdata (target_sum at 0x0)
//
// Items load one per cycle into the value store while the engine is idle.
// A last item starts the engine, which works on rows of W = ceil(MAX_TARGET/64)
// words; each row pass goes through the single-write reach memory one row word
// per cycle.
// in_ready is low while the engine runs; a result waits in the output register
// without blocking new items. Synchronous reset clears control state only.
module subset_sum_unneeded_counter_unit #(
  parameter int MAX_ITEMS  = 256,
  parameter int MAX_TARGET = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ssu_pkg::VAL_W-1:0]   item_value,
  input  logic                        is_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ssu_pkg::CNT_W-1:0]   unneeded_count,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssu_pkg::PADDR_W-1:0] paddr,
  input  logic [ssu_pkg::PDATA_W-1:0] pwdata,
  output logic [ssu_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int NW  = $clog2(MAX_ITEMS + 1);
  localparam int VAW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

  logic                      busy;
  logic [NW-1:0]             cnt;
  logic [NW-1:0]             cnt_inc;
  logic [ssu_pkg::TGT_W-1:0] target_sum;
  logic                      acc, store, load, reg_hit;
  logic [VAW-1:0]            vrd_addr;
  logic [ssu_pkg::VAL_W-1:0] vrd_data;
  ssu_pkg::cmd_t             cmd;
  ssu_pkg::res_t             res;

  // Input transaction and list fill
  assign in_ready = !busy;
  assign acc      = in_valid && in_ready;
  assign store    = acc && (32'(cnt) < MAX_ITEMS);
  assign cnt_inc  = store ? cnt + NW'(1) : cnt;

  assign cmd.go     = acc && is_last;
  assign cmd.target = target_sum;

  // Register access
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2:2] == 1'(ssu_pkg::REG_TARGET_SUM));
  assign prdata  = reg_hit ? ssu_pkg::PDATA_W'(target_sum) : '0;

  assign load = res.valid && (!out_valid || out_ready);

  ssu_value_mem #(.DEPTH(MAX_ITEMS), .AW(VAW)) u_values (
    .clk   (clk),
    .we    (store),
    .waddr (VAW'(cnt)),
    .wdata (item_value),
    .raddr (vrd_addr),
    .rdata (vrd_data)
  );

  ssu_engine #(
    .MAX_ITEMS  (MAX_ITEMS),
    .MAX_TARGET (MAX_TARGET),
    .NW         (NW),
    .VAW        (VAW)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .n         (cnt_inc),
    .vrd_addr  (vrd_addr),
    .vrd_data  (vrd_data),
    .res       (res),
    .res_ready (load)
  );

  // Hold the count, config and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      cnt        <= '0;
      target_sum <= ssu_pkg::TARGET_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && reg_hit) begin
        target_sum <= pwdata[ssu_pkg::TGT_W-1:0];
      end
      if (acc) begin
        if (is_last) begin
          cnt  <= '0;
          busy <= 1'b1;
        end else begin
          cnt <= cnt_inc;
        end
      end
      if (load) begin
        out_valid <= 1'b1;
        busy      <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      unneeded_count <= res.count;
    end
  end

endmodule

// File: rtl/core/ssu_checker.sv
module ssu_sva_checker #(
  parameter int MAX_ITEMS = 256
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        is_last,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ssu_pkg::CNT_W-1:0]   unneeded_count,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [ssu_pkg::PADDR_W-1:0] paddr,
  input logic [ssu_pkg::PDATA_W-1:0] pwdata,
  input logic [ssu_pkg::PDATA_W-1:0] prdata
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(unneeded_count))
    else $error("result changed while stalled");

  // A last item closes the input until its result is out
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && is_last |=> !in_ready)
    else $error("input open after last item");

  // A new result appears only after a busy period
  a_rose_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without computation");

  // Count never exceeds MAX_ITEMS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(unneeded_count) <= MAX_ITEMS))
    else $error("count out of range");

  // Target reads back what was written
  a_cfg_read: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && !paddr[2]
    |=> paddr[2] || (prdata[10:0] == $past(pwdata[10:0])))
    else $error("target readback mismatch");

endmodule

bind subset_sum_unneeded_counter_unit ssu_sva_checker #(.MAX_ITEMS(MAX_ITEMS)) u_ssu_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .is_last        (is_last),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .unneeded_count (unneeded_count),
  .psel           (psel),
  .penable        (penable),
  .pwrite         (pwrite),
  .paddr          (paddr),
  .pwdata         (pwdata),
  .prdata         (prdata)
);
